FILE: hw/rtl/elastic_occupancy_watermark_manager_macros.svh
// ----------------------------------------------------------------------------
// elastic occupancy watermark manager: assertion macros
// Concurrent assertion wrappers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ELASTIC_OCCUPANCY_WATERMARK_MANAGER_MACROS_SVH
`define ELASTIC_OCCUPANCY_WATERMARK_MANAGER_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property, ignored while reset is asserted
`define EOWM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked property that also holds during reset
`define EOWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EOWM_ASSERT(lbl, clk, rstn, prop, msg)
`define EOWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/eowm_pkg.sv
// ----------------------------------------------------------------------------
// eowm_pkg
// Types, codes and reset values of the elastic occupancy watermark manager.
// ----------------------------------------------------------------------------
package eowm_pkg;

	localparam int TH_W = 16;

	typedef enum logic [2:0] {
		OP_REQUEST = 3'd0,
		OP_RELEASE = 3'd1,
		OP_CHECK   = 3'd2,
		OP_EXPAND  = 3'd3,
		OP_SHRINK  = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		CFG_INIT_CAP  = 3'd0,
		CFG_MAX_CAP   = 3'd1,
		CFG_GROWTH    = 3'd2,
		CFG_SHRINK_TH = 3'd3,
		CFG_WARN_TH   = 3'd4,
		CFG_ELEV_TH   = 3'd5,
		CFG_FEATURES  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0]     init_cap;
		logic [31:0]     max_cap;
		logic [TH_W-1:0] grow_fac;
		logic [TH_W-1:0] shr_th;
		logic [TH_W-1:0] warn_th;
		logic [TH_W-1:0] elev_th;
		logic [2:0]      feature_enables;
	} cfg_t;

	localparam logic [31:0]     RST_INIT_CAP  = 32'd512;
	localparam logic [31:0]     RST_MAX_CAP   = 32'd0;
	localparam logic [TH_W-1:0] RST_GROWTH    = 16'd512;
	localparam logic [TH_W-1:0] RST_SHRINK_TH = 16'd16384;
	localparam logic [TH_W-1:0] RST_WARN_TH   = 16'd58982;
	localparam logic [TH_W-1:0] RST_ELEV_TH   = 16'd49152;
	localparam logic [2:0]      RST_FEATURES  = 3'd5;

	localparam int FEAT_AUTO_EXP = 0;
	localparam int FEAT_AUTO_SHR = 1;
	localparam int FEAT_CLEANUP  = 2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	localparam logic [1:0] LVL_NORMAL   = 2'd0;
	localparam logic [1:0] LVL_ELEVATED = 2'd1;
	localparam logic [1:0] LVL_WARNING  = 2'd2;
	localparam logic [1:0] LVL_CRITICAL = 2'd3;

	typedef enum logic {
		AR_MUL = 1'b0,
		AR_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_CHECK_CRIT,
		S_GROW_MUL,
		S_GROW_A,
		S_GROW_B,
		S_GROW_POST,
		S_SHR_UTIL,
		S_SHR_UTIL_W,
		S_SHR_START,
		S_SHR_DIV_W,
		S_SHR_CLAMP,
		S_SHR_COMMIT,
		S_LVL,
		S_LVL_W,
		S_LVL_E,
		S_DONE
	} state_t;

endpackage

FILE: hw/rtl/elastic_occupancy_watermark_manager.sv
// ----------------------------------------------------------------------------
// elastic_occupancy_watermark_manager
// Occupancy counter with elastic capacity, watermark levels and statistics.
// ----------------------------------------------------------------------------
// Usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register
//   per beat; it is always ready. Write only while no item is in flight.
// - in channel: a beat is taken when in_valid is high and in_stall is low.
//   in_stall is high from the taking beat until the result is in the output
//   register, so one item is worked on at a time.
// - out channel: one result beat per item, held in an output register until
//   out_valid is high and out_stall is low. A new item may be taken while
//   the previous result still waits; a finished item waits in the last
//   state until the output register is free.
// - sequence, taking beat to out_valid: dispatch, a critical test for a
//   check, a grow or a shrink when one runs (bit-serial divide,
//   COUNT_BITS + 8 steps), then level compares (fewer at warning, critical).
// - reset: occupancy, peak and counters clear, capacity takes the reset
//   initial capacity (saturated to COUNT_BITS), registers take reset values.
// ----------------------------------------------------------------------------
`include "elastic_occupancy_watermark_manager_macros.svh"

module elastic_occupancy_watermark_manager #(
	parameter int COUNT_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] new_count,
	input  logic        expand_ok,
	input  logic        shrink_ok,
	input  logic [31:0] cleanup_freed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [1:0]  level,
	output logic [31:0] occupancy,
	output logic [31:0] capacity_now,
	output logic [31:0] peak_occupancy,
	output logic [31:0] expansion_count,
	output logic [31:0] shrink_count,
	output logic [31:0] cleanup_count,
	output logic [31:0] failure_count
);
	import eowm_pkg::*;

	localparam int CW = COUNT_BITS;
	localparam int PW = COUNT_BITS + TH_W;
	localparam logic [31:0] FULL32 = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [CW-1:0] FULL = CW'(FULL32);
	localparam logic [CW-1:0] CAP_RST =
		(RST_INIT_CAP > FULL32) ? FULL : CW'(RST_INIT_CAP);

	cfg_t       cfg;
	arith_req_t ar_req;
	logic [TH_W-1:0] ar_opa;
	logic [PW-1:0]   ar_res;
	logic            ar_done;

	state_t state_q, state_d;

	logic [2:0]    op_q;
	logic [CW-1:0] newc_q;
	logic          eok_q, sok_q, freed_q;

	logic [CW-1:0] occ_q, cap_q, peak_q, ncap_q;
	logic [31:0]   exp_cnt_q, shr_cnt_q, cln_cnt_q, fail_cnt_q;
	logic          status_q, grow_ok_q;
	logic [1:0]    lvl_q;

	logic          out_valid_q;
	logic          out_status_q;
	logic [1:0]    out_level_q;
	logic [31:0]   out_occ_q, out_cap_q, out_peak_q;
	logic [31:0]   out_exp_q, out_shr_q, out_cln_q, out_fail_q;

	logic          in_acc, out_free;
	logic          auto_exp, auto_shr, cleanup_en;
	logic [CW-1:0] floor_cap, occ_inc;
	logic          crit_now;
	logic [TH_W-1:0] cmp_th;
	logic [PW-1:0] occ_sh;
	logic          util_ge;
	logic [CW-1:0] g_nc_sat, d_sat;
	logic          g_over, g_refuse, g_ok;
	logic [CW-1:0] g_new, s_new;
	logic          s_noop;

	eowm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	eowm_arith #(
		.COUNT_BITS (COUNT_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.opa    (ar_opa),
		.opb    (cap_q),
		.result (ar_res),
		.done   (ar_done)
	);

	assign cfg_ready = 1'b1;

	always_comb begin
		in_acc     = in_valid && !in_stall;
		out_free   = !out_valid_q || !out_stall;
		auto_exp   = cfg.feature_enables[FEAT_AUTO_EXP];
		auto_shr   = cfg.feature_enables[FEAT_AUTO_SHR];
		cleanup_en = cfg.feature_enables[FEAT_CLEANUP];
		floor_cap  = (cfg.init_cap > FULL32) ? FULL : cfg.init_cap[CW-1:0];
		occ_inc    = occ_q + CW'(1);
		crit_now   = (cap_q != '0) && (occ_q >= cap_q);

		// utilization compare: occupancy << FRACTION_BITS against threshold * capacity
		case (state_q)
			S_SHR_UTIL_W: cmp_th = cfg.shr_th;
			S_LVL_W:      cmp_th = cfg.warn_th;
			default:      cmp_th = cfg.elev_th;
		endcase
		occ_sh  = PW'({occ_q, {FRACTION_BITS{1'b0}}});
		util_ge = (cap_q == '0) ? (cmp_th == '0) : (occ_sh >= ar_res);

		// grow: floor(cap * factor / 256) saturated
		g_nc_sat = (|ar_res[PW-1:CW+8]) ? FULL : ar_res[CW+7:8];
		g_over   = (cfg.max_cap != '0) && (32'(ncap_q) > cfg.max_cap);
		g_refuse = g_over && (32'(cap_q) >= cfg.max_cap);
		g_ok     = !g_refuse && eok_q;
		g_new    = g_over ? cfg.max_cap[CW-1:0] : ncap_q;

		// shrink: quotient saturated, then floored
		d_sat  = (|ar_res[CW+7:CW]) ? FULL : ar_res[CW-1:0];
		s_new  = (ncap_q < floor_cap) ? floor_cap : ncap_q;
		s_noop = s_new >= cap_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (op_q)
					OP_REQUEST: begin
						if (occ_q != FULL && occ_q >= cap_q && auto_exp) state_d = S_GROW_MUL;
						else state_d = S_LVL;
					end
					OP_RELEASE: begin
						if (occ_q != '0 && auto_shr && cap_q > floor_cap) state_d = S_SHR_UTIL;
						else state_d = S_LVL;
					end
					OP_CHECK:  state_d = S_CHECK_CRIT;
					OP_EXPAND: state_d = S_GROW_MUL;
					OP_SHRINK: state_d = S_SHR_START;
					default:   state_d = S_LVL;
				endcase
			end
			S_CHECK_CRIT: begin
				if (crit_now && auto_exp) state_d = S_GROW_MUL;
				else state_d = S_LVL;
			end
			S_GROW_MUL: state_d = S_GROW_A;
			S_GROW_A: begin
				if (ar_done) begin
					if (g_nc_sat <= cap_q && cap_q == FULL) state_d = S_GROW_POST;
					else state_d = S_GROW_B;
				end
			end
			S_GROW_B:    state_d = S_GROW_POST;
			S_GROW_POST: state_d = S_LVL;
			S_SHR_UTIL:  state_d = S_SHR_UTIL_W;
			S_SHR_UTIL_W: begin
				if (ar_done) begin
					if (!util_ge) state_d = S_SHR_START;
					else state_d = S_LVL;
				end
			end
			S_SHR_START: begin
				if (cfg.grow_fac == '0) state_d = S_SHR_CLAMP;
				else state_d = S_SHR_DIV_W;
			end
			S_SHR_DIV_W: begin
				if (ar_done) state_d = S_SHR_CLAMP;
			end
			S_SHR_CLAMP:  state_d = S_SHR_COMMIT;
			S_SHR_COMMIT: state_d = S_LVL;
			S_LVL: begin
				if (crit_now) state_d = S_DONE;
				else state_d = S_LVL_W;
			end
			S_LVL_W: begin
				if (ar_done) begin
					if (util_ge) state_d = S_DONE;
					else state_d = S_LVL_E;
				end
			end
			S_LVL_E: begin
				if (ar_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: shared unit requests and input stall
	always_comb begin
		ar_req.start = 1'b0;
		ar_req.op    = AR_MUL;
		ar_opa       = cfg.grow_fac;
		in_stall     = state_q != S_IDLE;
		case (state_q)
			S_GROW_MUL: begin
				ar_req.start = 1'b1;
			end
			S_SHR_UTIL: begin
				ar_req.start = 1'b1;
				ar_opa       = cfg.shr_th;
			end
			S_SHR_START: begin
				ar_req.start = cfg.grow_fac != '0;
				ar_req.op    = AR_DIV;
			end
			S_LVL: begin
				ar_req.start = !crit_now;
				ar_opa       = cfg.warn_th;
			end
			S_LVL_W: begin
				ar_req.start = ar_done && !util_ge;
				ar_opa       = cfg.elev_th;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			cap_q      <= CAP_RST;
			peak_q     <= '0;
			exp_cnt_q  <= '0;
			shr_cnt_q  <= '0;
			cln_cnt_q  <= '0;
			fail_cnt_q <= '0;
		end else begin
			case (state_q)
				S_DISPATCH: begin
					case (op_q)
						OP_REQUEST: begin
							if (occ_q == FULL || (occ_q >= cap_q && !auto_exp)) begin
								fail_cnt_q <= fail_cnt_q + 32'd1;
							end else if (occ_q < cap_q) begin
								occ_q <= occ_inc;
								if (occ_inc > peak_q) peak_q <= occ_inc;
							end
						end
						OP_RELEASE: begin
							if (occ_q != '0) occ_q <= occ_q - CW'(1);
						end
						OP_CHECK: begin
							if (newc_q != occ_q) begin
								occ_q <= newc_q;
								if (newc_q > peak_q) peak_q <= newc_q;
							end
						end
						OP_CLEAR: begin
							peak_q     <= '0;
							exp_cnt_q  <= '0;
							shr_cnt_q  <= '0;
							cln_cnt_q  <= '0;
							fail_cnt_q <= '0;
						end
						default: ;
					endcase
				end
				S_GROW_B: begin
					if (g_ok) begin
						cap_q     <= g_new;
						exp_cnt_q <= exp_cnt_q + 32'd1;
					end
				end
				S_GROW_POST: begin
					if (op_q == OP_REQUEST) begin
						if (grow_ok_q || (cleanup_en && freed_q)) begin
							if (!grow_ok_q) cln_cnt_q <= cln_cnt_q + 32'd1;
							occ_q <= occ_inc;
							if (occ_inc > peak_q) peak_q <= occ_inc;
						end else begin
							fail_cnt_q <= fail_cnt_q + 32'd1;
						end
					end
				end
				S_SHR_COMMIT: begin
					if (!s_noop && sok_q) begin
						cap_q     <= s_new;
						shr_cnt_q <= shr_cnt_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q     <= opcode;
					newc_q   <= new_count[CW-1:0];
					eok_q    <= expand_ok;
					sok_q    <= shrink_ok;
					freed_q  <= |cleanup_freed;
					status_q <= ST_OK;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_REQUEST: begin
						if (occ_q == FULL || (occ_q >= cap_q && !auto_exp)) status_q <= ST_FAIL;
					end
					OP_RELEASE: begin
						if (occ_q == '0) status_q <= ST_FAIL;
					end
					OP_CHECK, OP_EXPAND, OP_SHRINK, OP_CLEAR: ;
					default: status_q <= ST_FAIL;
				endcase
			end
			S_GROW_A: begin
				if (ar_done) begin
					grow_ok_q <= 1'b0;
					if (g_nc_sat <= cap_q) ncap_q <= cap_q + CW'(1);
					else ncap_q <= g_nc_sat;
				end
			end
			S_GROW_B: begin
				grow_ok_q <= g_ok;
			end
			S_GROW_POST: begin
				case (op_q)
					OP_REQUEST: begin
						if (!grow_ok_q && !(cleanup_en && freed_q)) status_q <= ST_FAIL;
					end
					OP_EXPAND: begin
						status_q <= grow_ok_q ? ST_OK : ST_FAIL;
					end
					default: ;
				endcase
			end
			S_SHR_START: begin
				if (cfg.grow_fac == '0) ncap_q <= cap_q;
			end
			S_SHR_DIV_W: begin
				if (ar_done) ncap_q <= d_sat;
			end
			S_SHR_CLAMP: begin
				if (ncap_q < occ_q) ncap_q <= occ_q;
			end
			S_SHR_COMMIT: begin
				if (!s_noop && !sok_q && op_q == OP_SHRINK) status_q <= ST_FAIL;
			end
			S_LVL: begin
				if (crit_now) lvl_q <= LVL_CRITICAL;
			end
			S_LVL_W: begin
				if (ar_done && util_ge) lvl_q <= LVL_WARNING;
			end
			S_LVL_E: begin
				if (ar_done) lvl_q <= util_ge ? LVL_ELEVATED : LVL_NORMAL;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			out_level_q  <= lvl_q;
			out_occ_q    <= 32'(occ_q);
			out_cap_q    <= 32'(cap_q);
			out_peak_q   <= 32'(peak_q);
			out_exp_q    <= exp_cnt_q;
			out_shr_q    <= shr_cnt_q;
			out_cln_q    <= cln_cnt_q;
			out_fail_q   <= fail_cnt_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign level           = out_level_q;
	assign occupancy       = out_occ_q;
	assign capacity_now    = out_cap_q;
	assign peak_occupancy  = out_peak_q;
	assign expansion_count = out_exp_q;
	assign shrink_count    = out_shr_q;
	assign cleanup_count   = out_cln_q;
	assign failure_count   = out_fail_q;

	`EOWM_ASSERT(a_out_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result beat without finished item")
	`EOWM_ASSERT(a_cap_commit, clk, arst_n, cap_q != $past(cap_q) |-> ($past(state_q) == S_GROW_B || $past(state_q) == S_SHR_COMMIT), "capacity changed outside commit")
	`EOWM_ASSERT(a_out_load, clk, arst_n, (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE), "finished item not handed over")

endmodule

FILE: hw/rtl/eowm_cfg.sv
// ----------------------------------------------------------------------------
// eowm_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module eowm_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [31:0]   wr_data,
	output eowm_pkg::cfg_t cfg
);
	import eowm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_cap        <= RST_INIT_CAP;
			cfg_q.max_cap         <= RST_MAX_CAP;
			cfg_q.grow_fac        <= RST_GROWTH;
			cfg_q.shr_th          <= RST_SHRINK_TH;
			cfg_q.warn_th         <= RST_WARN_TH;
			cfg_q.elev_th         <= RST_ELEV_TH;
			cfg_q.feature_enables <= RST_FEATURES;
		end else if (wr_en) begin
			case (wr_index)
				CFG_INIT_CAP:  cfg_q.init_cap        <= wr_data;
				CFG_MAX_CAP:   cfg_q.max_cap         <= wr_data;
				CFG_GROWTH:    cfg_q.grow_fac        <= wr_data[TH_W-1:0];
				CFG_SHRINK_TH: cfg_q.shr_th          <= wr_data[TH_W-1:0];
				CFG_WARN_TH:   cfg_q.warn_th         <= wr_data[TH_W-1:0];
				CFG_ELEV_TH:   cfg_q.elev_th         <= wr_data[TH_W-1:0];
				CFG_FEATURES:  cfg_q.feature_enables <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/eowm_arith.sv
// ----------------------------------------------------------------------------
// eowm_arith
// Shared arithmetic unit: registered 16 x COUNT_BITS multiply, or a restoring
// divide of (opb << 8) by opa, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "elastic_occupancy_watermark_manager_macros.svh"

module eowm_arith #(
	parameter int COUNT_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  eowm_pkg::arith_req_t    req,
	input  logic [15:0]             opa,
	input  logic [COUNT_BITS-1:0]   opb,
	output logic [COUNT_BITS+15:0]  result,
	output logic                    done
);
	import eowm_pkg::*;

	localparam int DW    = COUNT_BITS + 8;
	localparam int PW    = COUNT_BITS + TH_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [PW-1:0]    res_q;
	logic [DW-1:0]    dvd_q;
	logic [TH_W-1:0]  rem_q;
	logic [TH_W-1:0]  dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TH_W:0]    trial;
	logic             take;
	logic [TH_W-1:0]  rem_nxt;
	logic [DW-1:0]    dvd_nxt;
	logic             last;

	// one restoring step: quotient bits shift in at the bottom of dvd_q
	always_comb begin
		trial   = {rem_q, dvd_q[DW-1]};
		take    = trial >= {1'b0, dsr_q};
		rem_nxt = take ? TH_W'(trial - {1'b0, dsr_q}) : trial[TH_W-1:0];
		dvd_nxt = {dvd_q[DW-2:0], take};
		last    = cnt_q == CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.op == AR_MUL) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == AR_MUL) begin
				res_q <= PW'(opa) * PW'(opb);
			end else begin
				dvd_q <= {opb, 8'd0};
				rem_q <= '0;
				dsr_q <= opa;
			end
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
			if (last) begin
				res_q <= PW'(dvd_nxt);
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

	`EOWM_ASSERT(a_start_idle, clk, arst_n, req.start |-> !busy_q, "start while divider busy")
	`EOWM_ASSERT(a_mul_lat, clk, arst_n, (req.start && req.op == AR_MUL) |=> done_q, "multiply late")
	`EOWM_ASSERT(a_div_lat, clk, arst_n, (req.start && req.op == AR_DIV) |-> ##(DW + 1) done_q, "divide late")
	`EOWM_ASSERT_ALWAYS(a_busy_done, clk, !(busy_q && done_q), "done flagged while busy")

endmodule

FILE: sim/tb_elastic_occupancy_watermark_manager.sv
// ----------------------------------------------------------------------------
// tb_elastic_occupancy_watermark_manager
// Self-checking bench: a directed table (reset behavior, error codes, grow
// and shrink corner cases) followed by randomized phases under several
// register settings. Each result beat is checked against a behavioral
// counter model or pinned result; gaps and stalls are random on both sides.
// ----------------------------------------------------------------------------
module tb_elastic_occupancy_watermark_manager;
	import eowm_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 5;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 120;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PRINT_LIMIT     = 60;

	localparam logic [31:0] FULL_SCALE = 32'hFFFF_FFFF;
	localparam logic [2:0]  OP_SPARE_A = 3'd6;
	localparam logic [2:0]  OP_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] new_count;
		logic        eok;
		logic        sok;
		logic [31:0] freed;
	} event_t;

	typedef struct packed {
		logic        status;
		logic [1:0]  level;
		logic [31:0] occ;
		logic [31:0] cap;
		logic [31:0] peak;
		logic [31:0] grows;
		logic [31:0] shrinks;
		logic [31:0] cleanups;
		logic [31:0] refused;
	} outcome_t;

	typedef struct packed {
		logic     is_reg;
		cfg_idx_t reg_idx;
		logic [31:0] reg_val;
		event_t   ev;
		logic     pinned;
		outcome_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [31:0] new_count;
	logic        expand_ok;
	logic        shrink_ok;
	logic [31:0] cleanup_freed;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [1:0]  level;
	logic [31:0] occupancy;
	logic [31:0] capacity_now;
	logic [31:0] peak_occupancy;
	logic [31:0] expansion_count;
	logic [31:0] shrink_count;
	logic [31:0] cleanup_count;
	logic [31:0] failure_count;

	// model of the block: occupancy state and register copies
	logic [31:0] slots_used, slots_cap, slots_peak;
	logic [31:0] n_grows, n_shrinks, n_cleanups, n_refused;
	logic [31:0] cap_floor, cap_ceiling;
	logic [15:0] factor_q88, shrink_frac, warn_frac, elev_frac;
	logic [2:0]  feat;

	outcome_t  pending_results[$];
	plan_row_t plan[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  directed_items = 0;
	int  results_seen = 0;
	int  refusals_seen = 0;
	int  criticals_seen = 0;
	int  quiet_cycles = 0;
	bit  steady = 1'b0;
	bit  hold_off_req = 1'b0;

	elastic_occupancy_watermark_manager dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.new_count       (new_count),
		.expand_ok       (expand_ok),
		.shrink_ok       (shrink_ok),
		.cleanup_freed   (cleanup_freed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.level           (level),
		.occupancy       (occupancy),
		.capacity_now    (capacity_now),
		.peak_occupancy  (peak_occupancy),
		.expansion_count (expansion_count),
		.shrink_count    (shrink_count),
		.cleanup_count   (cleanup_count),
		.failure_count   (failure_count)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [31:0] clip_count(logic [63:0] v);
		return (v > 64'(FULL_SCALE)) ? FULL_SCALE : v[31:0];
	endfunction

	// count/c >= th/2^16; an empty capacity reads as zero utilization
	function automatic bit frac_reached(logic [31:0] count, logic [31:0] c, logic [15:0] th);
		if (c == 32'd0)
			return th == 16'd0;
		return {16'h0, count, 16'h0} >= 64'(th) * 64'(c);
	endfunction

	function automatic logic [1:0] watermark(logic [31:0] count, logic [31:0] c);
		if (c != 32'd0 && count >= c)
			return LVL_CRITICAL;
		if (frac_reached(count, c, warn_frac))
			return LVL_WARNING;
		if (frac_reached(count, c, elev_frac))
			return LVL_ELEVATED;
		return LVL_NORMAL;
	endfunction

	function automatic bit grow_capacity(logic ok);
		logic [31:0] grown;
		grown = clip_count((64'(slots_cap) * 64'(factor_q88)) >> 8);
		// growth of at least one slot
		if (grown <= slots_cap) begin
			if (slots_cap == FULL_SCALE)
				return 1'b0;
			grown = slots_cap + 32'd1;
		end
		if (cap_ceiling != 32'd0 && grown > cap_ceiling) begin
			if (slots_cap >= cap_ceiling)
				return 1'b0;
			grown = cap_ceiling;
		end
		if (!ok)
			return 1'b0;
		slots_cap = grown;
		n_grows += 32'd1;
		return 1'b1;
	endfunction

	function automatic bit shrink_capacity(logic ok);
		logic [31:0] target;
		target = slots_cap;
		if (factor_q88 != 16'd0)
			target = clip_count(64'({slots_cap, 8'h00}) / 64'(factor_q88));
		if (target < slots_used)
			target = slots_used;
		if (target < cap_floor)
			target = cap_floor;
		if (target >= slots_cap)
			return 1'b1;
		if (!ok)
			return 1'b0;
		slots_cap = target;
		n_shrinks += 32'd1;
		return 1'b1;
	endfunction

	function automatic outcome_t apply_event(event_t ev);
		outcome_t r;
		bit go;
		r = '0;
		r.status = ST_OK;
		case (ev.op)
			OP_REQUEST: begin
				go = 1'b1;
				if (slots_used == FULL_SCALE) begin
					go = 1'b0;
				end else if (slots_used >= slots_cap) begin
					if (!feat[FEAT_AUTO_EXP]) begin
						go = 1'b0;
					end else if (!grow_capacity(ev.eok)) begin
						// fall back to cleanup when growth is refused
						if (feat[FEAT_CLEANUP] && ev.freed != 32'd0)
							n_cleanups += 32'd1;
						else
							go = 1'b0;
					end
				end
				if (go) begin
					slots_used += 32'd1;
					if (slots_used > slots_peak)
						slots_peak = slots_used;
				end else begin
					n_refused += 32'd1;
					r.status = ST_FAIL;
				end
			end
			OP_RELEASE: begin
				if (slots_used == 32'd0) begin
					r.status = ST_FAIL;
				end else begin
					slots_used -= 32'd1;
					if (feat[FEAT_AUTO_SHR] && slots_cap > cap_floor &&
					    !frac_reached(slots_used, slots_cap, shrink_frac))
						void'(shrink_capacity(ev.sok));
				end
			end
			OP_CHECK: begin
				if (ev.new_count != slots_used) begin
					slots_used = ev.new_count;
					if (slots_used > slots_peak)
						slots_peak = slots_used;
				end
				if (watermark(slots_used, slots_cap) == LVL_CRITICAL && feat[FEAT_AUTO_EXP])
					void'(grow_capacity(ev.eok));
			end
			OP_EXPAND: r.status = grow_capacity(ev.eok) ? ST_OK : ST_FAIL;
			OP_SHRINK: r.status = shrink_capacity(ev.sok) ? ST_OK : ST_FAIL;
			OP_CLEAR: begin
				slots_peak = 32'd0;
				n_grows = 32'd0;
				n_shrinks = 32'd0;
				n_cleanups = 32'd0;
				n_refused = 32'd0;
			end
			default: r.status = ST_FAIL;
		endcase
		r.level = watermark(slots_used, slots_cap);
		r.occ = slots_used;
		r.cap = slots_cap;
		r.peak = slots_peak;
		r.grows = n_grows;
		r.shrinks = n_shrinks;
		r.cleanups = n_cleanups;
		r.refused = n_refused;
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_event(logic [2:0] op, logic [31:0] nc, logic eok, logic sok,
					  logic [31:0] freed);
		plan_row_t r;
		r = '0;
		r.ev.op = op;
		r.ev.new_count = nc;
		r.ev.eok = eok;
		r.ev.sok = sok;
		r.ev.freed = freed;
		plan.push_back(r);
	endfunction

	// typed-in result for the last row; counters are all still zero there
	function automatic void pin_last(logic st, logic [1:0] lvl, logic [31:0] occ,
					 logic [31:0] cap, logic [31:0] pk);
		int k;
		k = plan.size() - 1;
		plan[k].pinned = 1'b1;
		plan[k].want.status = st;
		plan[k].want.level = lvl;
		plan[k].want.occ = occ;
		plan[k].want.cap = cap;
		plan[k].want.peak = pk;
	endfunction

	function automatic void add_reg(cfg_idx_t idx, logic [31:0] val);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		plan.push_back(r);
	endfunction

	task automatic log_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
				results_seen, name, got, want));
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_INIT_CAP:  cap_floor = val;
			CFG_MAX_CAP:   cap_ceiling = val;
			CFG_GROWTH:    factor_q88 = val[15:0];
			CFG_SHRINK_TH: shrink_frac = val[15:0];
			CFG_WARN_TH:   warn_frac = val[15:0];
			CFG_ELEV_TH:   elev_frac = val[15:0];
			CFG_FEATURES:  feat = val[2:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with nothing in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(event_t ev, logic pinned, outcome_t pinned_res);
		outcome_t r;
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= ev.op;
		new_count <= ev.new_count;
		expand_ok <= ev.eok;
		shrink_ok <= ev.sok;
		cleanup_freed <= ev.freed;
		do @(posedge clk); while (in_stall);
		r = apply_event(ev);
		pending_results.push_back(pinned ? pinned_res : r);
		items_sent++;
	endtask

	initial begin : stimulus
		event_t ev;
		logic [31:0] s_init, s_max;
		logic [15:0] s_growth, s_shr, s_warn, s_elev;
		logic [2:0]  s_feat;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 3'd0;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		opcode = 3'd0;
		new_count = 32'd0;
		expand_ok = 1'b0;
		shrink_ok = 1'b0;
		cleanup_freed = 32'd0;

		cap_floor = RST_INIT_CAP;
		cap_ceiling = RST_MAX_CAP;
		factor_q88 = RST_GROWTH;
		shrink_frac = RST_SHRINK_TH;
		warn_frac = RST_WARN_TH;
		elev_frac = RST_ELEV_TH;
		feat = RST_FEATURES;
		slots_used = 32'd0;
		slots_cap = RST_INIT_CAP;
		slots_peak = 32'd0;
		n_grows = 32'd0;
		n_shrinks = 32'd0;
		n_cleanups = 32'd0;
		n_refused = 32'd0;

		// directed table, starting from the reset settings
		add_event(OP_RELEASE, 32'd0, 1'b1, 1'b1, 32'd0);
		pin_last(ST_FAIL, LVL_NORMAL, 32'd0, 32'd512, 32'd0);
		add_event(OP_REQUEST, 32'd0, 1'b1, 1'b1, 32'd0);
		pin_last(ST_OK, LVL_NORMAL, 32'd1, 32'd512, 32'd1);
		add_event(OP_SPARE_A, FULL_SCALE, 1'b1, 1'b1, FULL_SCALE);
		pin_last(ST_FAIL, LVL_NORMAL, 32'd1, 32'd512, 32'd1);
		add_event(OP_SPARE_B, 32'd0, 1'b0, 1'b0, 32'd0);
		pin_last(ST_FAIL, LVL_NORMAL, 32'd1, 32'd512, 32'd1);
		add_event(OP_CHECK, 32'd512, 1'b1, 1'b0, 32'd0);
		add_event(OP_CHECK, 32'd1024, 1'b0, 1'b0, 32'd0);
		add_event(OP_REQUEST, 32'd0, 1'b0, 1'b0, 32'd0);
		add_event(OP_REQUEST, 32'd0, 1'b0, 1'b0, FULL_SCALE);
		add_event(OP_REQUEST, 32'd0, 1'b1, 1'b0, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b0, 1'b1, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_SHRINK, 32'd0, 1'b1, 1'b0, 32'd0);
		add_event(OP_SHRINK, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_CHECK, FULL_SCALE, 1'b1, 1'b1, 32'd0);
		add_event(OP_REQUEST, 32'd0, 1'b1, 1'b1, FULL_SCALE);
		add_event(OP_CLEAR, 32'd0, 1'b0, 1'b0, 32'd0);
		// factor below one still grows by a slot
		add_reg(CFG_FEATURES, 32'd7);
		add_reg(CFG_GROWTH, 32'd128);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		// clamp at the ceiling, then refuse at it
		add_reg(CFG_MAX_CAP, 32'd5000);
		add_reg(CFG_GROWTH, 32'd65535);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		// unlimited: saturate at full scale, then refuse
		add_reg(CFG_MAX_CAP, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		add_event(OP_EXPAND, 32'd0, 1'b1, 1'b1, 32'd0);
		// release with auto shrink down from full scale
		add_reg(CFG_INIT_CAP, 32'd1000);
		add_reg(CFG_SHRINK_TH, 32'd65535);
		add_event(OP_CHECK, 32'd1, 1'b0, 1'b0, 32'd0);
		add_event(OP_RELEASE, 32'd0, 1'b0, 1'b1, 32'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_item(plan[i].ev, plan[i].pinned, plan[i].want);
			end
		end
		directed_items = items_sent;

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			s_init = $urandom_range(0, 1) ? 32'($urandom_range(0, 4096)) : $urandom();
			s_max = ($urandom_range(0, 2) == 0) ? 32'd0 :
				($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 20000));
			case ($urandom_range(0, 3))
				0: s_growth = 16'($urandom_range(1, 255));
				1: s_growth = 16'($urandom_range(257, 1024));
				2: s_growth = 16'd256;
				default: s_growth = 16'($urandom_range(1, 65535));
			endcase
			s_shr = 16'($urandom());
			s_warn = 16'($urandom());
			s_elev = 16'($urandom());
			s_feat = 3'($urandom_range(0, 7));
			case (p)
				0: begin
					s_init = 32'd0;
					s_max = 32'd0;
					s_growth = 16'd1;
					s_shr = 16'd0;
					s_warn = 16'd0;
					s_elev = 16'd0;
					s_feat = 3'd0;
				end
				1: begin
					s_init = FULL_SCALE;
					s_max = FULL_SCALE;
					s_growth = 16'hFFFF;
					s_shr = 16'hFFFF;
					s_warn = 16'hFFFF;
					s_elev = 16'hFFFF;
					s_feat = 3'd7;
				end
				// zero floor and a steep factor let capacity drain to zero
				2: begin
					s_init = 32'd0;
					s_max = 32'd0;
					s_growth = 16'hFFFF;
					s_feat = 3'd7;
				end
				3: begin
					s_init = RST_INIT_CAP;
					s_max = RST_MAX_CAP;
					s_growth = RST_GROWTH;
					s_shr = RST_SHRINK_TH;
					s_warn = RST_WARN_TH;
					s_elev = RST_ELEV_TH;
					s_feat = RST_FEATURES;
				end
				default: ;
			endcase
			write_reg(CFG_INIT_CAP, s_init);
			write_reg(CFG_MAX_CAP, s_max);
			write_reg(CFG_GROWTH, 32'(s_growth));
			write_reg(CFG_SHRINK_TH, 32'(s_shr));
			write_reg(CFG_WARN_TH, 32'(s_warn));
			write_reg(CFG_ELEV_TH, 32'(s_elev));
			write_reg(CFG_FEATURES, 32'(s_feat));
			steady = (p % 3 == 1);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 3 && n == 40)
					hold_off_req = 1'b1;
				case ($urandom_range(0, 99)) inside
					[0:31]:  ev.op = OP_REQUEST;
					[32:51]: ev.op = OP_RELEASE;
					[52:69]: ev.op = OP_CHECK;
					[70:79]: ev.op = OP_EXPAND;
					[80:89]: ev.op = OP_SHRINK;
					[90:94]: ev.op = OP_CLEAR;
					default: ev.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
				endcase
				// counts near capacity reach the full and threshold paths
				case ($urandom_range(0, 7))
					0: ev.new_count = slots_cap;
					1: ev.new_count = slots_cap - 32'd1;
					2: ev.new_count = slots_cap + 32'd1;
					3: ev.new_count = 32'd0;
					4: ev.new_count = FULL_SCALE;
					5: ev.new_count = 32'($urandom_range(0, slots_cap));
					6: ev.new_count = 32'((64'(slots_cap) *
						64'($urandom_range(0, 65535))) >> 16);
					default: ev.new_count = $urandom();
				endcase
				ev.eok = ($urandom_range(0, 3) != 0);
				ev.sok = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 3))
					0, 1: ev.freed = 32'd0;
					2: ev.freed = $urandom();
					default: ev.freed = $urandom_range(0, 1) ? FULL_SCALE : 32'd1;
				endcase
				send_item(ev, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		steady = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d items (%0d from the directed table) over %0d settings",
			items_sent, directed_items, NUM_PHASES + 1);
		$display("%0d results compared, %0d refused, %0d at critical level, %0d mismatches",
			results_seen, refusals_seen, criticals_seen, mismatches);
		if (mismatches == 0)
			$display("elastic_occupancy_watermark_manager test passed");
		else
			$display("elastic_occupancy_watermark_manager test failed");
		$finish;
	end

	// result side: random stalls plus one long hold-off to back up the input
	initial begin : result_sink
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!steady && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (1 + idle_len()) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (steady ? 8 : $urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_monitor
		outcome_t w;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (status == ST_FAIL)
				refusals_seen++;
			if (level == LVL_CRITICAL)
				criticals_seen++;
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("result %0d arrived with nothing pending",
					results_seen));
			end else begin
				w = pending_results.pop_front();
				check_field("status", 32'(status), 32'(w.status));
				check_field("level", 32'(level), 32'(w.level));
				check_field("occupancy", occupancy, w.occ);
				check_field("capacity_now", capacity_now, w.cap);
				check_field("peak_occupancy", peak_occupancy, w.peak);
				check_field("expansion_count", expansion_count, w.grows);
				check_field("shrink_count", shrink_count, w.shrinks);
				check_field("cleanup_count", cleanup_count, w.cleanups);
				check_field("failure_count", failure_count, w.refused);
			end
		end
	end

	// no beat on any channel for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results pending",
					quiet_cycles, pending_results.size());
				$display("elastic_occupancy_watermark_manager test failed");
				$finish;
			end
		end
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/eowm_pkg.sv
hw/rtl/eowm_cfg.sv
hw/rtl/eowm_arith.sv
hw/rtl/elastic_occupancy_watermark_manager.sv
sim/tb_elastic_occupancy_watermark_manager.sv
